// ===== hdl/mfrt_pkg.sv =====
// Package: shared types, constants and codes for the fragment reassembly table.
package mfrt_pkg;

    localparam int GROUPS_DEF  = 5;
    localparam int PARTS_DEF   = 10;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    localparam logic [2:0] KIND_SINGLE   = 3'd0;
    localparam logic [2:0] KIND_STORED   = 3'd1;
    localparam logic [2:0] KIND_DUP      = 3'd2;
    localparam logic [2:0] KIND_RANGE    = 3'd3;
    localparam logic [2:0] KIND_COMPLETE = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PICK,
        ST_UPDATE,
        ST_STATUS,
        ST_READOUT,
        ST_WRCLR,
        ST_MARK_RD,
        ST_MARK_CHK,
        ST_TICK_RD,
        ST_TICK_CHK
    } t_state;

endpackage

// ===== hdl/mfrt_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module mfrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/message_fragment_reassembly_table.sv =====
// Top level: multi-part message reassembly table with a group memory and a sequencer.
//
//  channel   | dir | handshake               | payload
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: ref, sender, part, total; tuser: command
//  m_axis    | out | m_axis_tvalid/tready    | tdata: slot..sender; tuser: kind; tlast: last
//  cfg       | in  | i_cfg_valid/o_cfg_ready | timeout limit in ticks
//
// One item at a time. After reset a clearing pass over all GROUPS slots runs before the
// first beat is taken. A single answers in the cycle after its beat is taken. A part
// is accepted, then slots are scanned (up to the matching slot, else all GROUPS), then
// pick, update and status steps run, then a complete group is read out part by part.
// A tick is accepted, then a marking pass and a flush pass run over every group, with
// the readout beats and one further step for each group flushed. A stalled output
// holds the sequencer; s_axis_tready stays low until the last result of the item has
// left the output register.
module message_fragment_reassembly_table
    import mfrt_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int PARTS  = PARTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // ref[15:0], sender[79:16], part[87:80], total[95:88]
    input  logic         s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,   // slot[2:0], part_index[6:3], present[7], group_ref[23:8], group_sender[87:24]
    output logic [2:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PW = $clog2(PARTS + 1);
    localparam int IW = $clog2(PARTS);
    // entry: used, ref, sender, total, received, start, seen
    localparam int EW = 1 + 16 + 64 + PW + PW + 32 + PARTS;

    typedef struct packed {
        logic             used;
        logic [15:0]      ref_num;
        logic [63:0]      sender;
        logic [PW-1:0]    total;
        logic [PW-1:0]    rcvd;
        logic [31:0]      start;
        logic [PARTS-1:0] seen;
    } t_entry;

    t_state r_state, n_state;
    logic [31:0]   r_timeout, r_now, n_now;
    logic [GW-1:0] r_g, n_g;          // scan index
    logic [GW-1:0] r_sel, n_sel;      // chosen slot
    logic          r_found, n_found, r_free, n_free;
    logic [GW-1:0] r_best, n_best;
    logic [31:0]   r_best_t, n_best_t;
    logic [IW-1:0] r_i, n_i;
    logic [2:0]    r_rkind, n_rkind;
    t_entry        r_ent, n_ent;
    logic [GROUPS-1:0] r_mask, n_mask; // groups due for a timeout flush on this tick
    logic [15:0]   r_ref;
    logic [63:0]   r_snd;
    logic [7:0]    r_part, r_total;
    logic          n_cmd_ld;

    logic          r_ov, n_ov;
    logic [2:0]    r_okind, n_okind;
    logic [2:0]    r_oslot, n_oslot;
    logic [3:0]    r_oidx, n_oidx;
    logic          r_opres, n_opres, r_olast, n_olast;
    logic [15:0]   r_oref, n_oref;
    logic [63:0]   r_osnd, n_osnd;

    logic          we;
    logic [GW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic [EW-1:0] rraw;

    mfrt_ram #(.WIDTH(EW), .DEPTH(GROUPS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rraw)
    );
    assign rdata = t_entry'(rraw);

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {r_osnd, r_oref, r_opres, r_oidx, r_oslot};

    logic out_free;
    assign out_free = !r_ov || m_axis_tready;

    logic [PW-1:0] clamp;
    logic [IW-1:0] pidx;
    logic          last_g;
    always_comb begin
        clamp  = (r_total > 8'(PARTS)) ? PW'(PARTS) : PW'(r_total);
        pidx   = IW'(r_part - 8'd1);
        last_g = (r_g == GW'(GROUPS - 1));
    end

    // any group above the current slot also due for flushing
    logic later_flush;
    always_comb begin
        later_flush = 1'b0;
        for (int k = 0; k < GROUPS; k++) begin
            if ((GW'(k) > r_g) && r_mask[k]) begin
                later_flush = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state; n_now = r_now; n_g = r_g; n_sel = r_sel;
        n_found = r_found; n_free = r_free; n_best = r_best; n_best_t = r_best_t;
        n_i = r_i; n_rkind = r_rkind; n_ent = r_ent; n_cmd_ld = 1'b0;
        n_mask = r_mask;
        n_ov = r_ov && !m_axis_tready;
        n_okind = r_okind; n_oslot = r_oslot; n_oidx = r_oidx; n_opres = r_opres;
        n_olast = r_olast; n_oref = r_oref; n_osnd = r_osnd;
        we = 1'b0; waddr = r_g; wdata = '0; raddr = r_g;
        case (r_state)
            ST_CLEAR: begin
                we = 1'b1;
                n_g = r_g + 1'b1;
                if (last_g) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_g = '0;
                raddr = '0;
                if (s_axis_tvalid && s_axis_tready) begin
                    n_cmd_ld = 1'b1;
                    n_found = 1'b0; n_free = 1'b0;
                    if (s_axis_tuser) begin
                        n_now = r_now + 32'd1;
                        n_state = ST_MARK_RD;
                    end else if (s_axis_tdata[95:88] <= 8'd1 || s_axis_tdata[87:80] == 8'd0) begin
                        n_ov = 1'b1; n_okind = KIND_SINGLE; n_oslot = '0; n_oidx = '0;
                        n_opres = 1'b0; n_oref = '0; n_osnd = '0; n_olast = 1'b1;
                    end else begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                // first match wins; else first free; else oldest start
                if (rdata.used && rdata.ref_num == r_ref && rdata.sender == r_snd) begin
                    n_found = 1'b1; n_sel = r_g;
                    n_state = ST_PICK;
                end else begin
                    if (!rdata.used && !r_free) begin
                        n_free = 1'b1; n_best = r_g;
                    end else if (!r_free && rdata.used &&
                                 (r_g == '0 || rdata.start < r_best_t)) begin
                        n_best = r_g; n_best_t = rdata.start;
                    end
                    n_g = r_g + 1'b1;
                    n_state = last_g ? ST_PICK : ST_SCAN_RD;
                end
                raddr = r_g + 1'b1;
            end
            ST_PICK: begin
                if (!r_found) begin
                    n_sel = r_best;
                end
                raddr = r_found ? r_sel : r_best;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (r_found) begin
                    n_ent = rdata;
                end else begin
                    n_ent = '0; n_ent.used = 1'b1; n_ent.ref_num = r_ref;
                    n_ent.sender = r_snd; n_ent.total = clamp; n_ent.start = r_now;
                end
                if (r_part > 8'(PARTS)) begin
                    n_rkind = KIND_RANGE;
                end else if (n_ent.seen[pidx]) begin
                    n_rkind = KIND_DUP;
                end else begin
                    n_rkind = KIND_STORED;
                    n_ent.seen[pidx] = 1'b1;
                    n_ent.rcvd = n_ent.rcvd + 1'b1;
                end
                n_state = ST_STATUS;
            end
            ST_STATUS: begin
                if (out_free) begin
                    n_ov = 1'b1; n_okind = r_rkind; n_oslot = 3'(r_sel);
                    n_oidx = (r_rkind == KIND_RANGE) ? 4'd0 : 4'(pidx);
                    n_opres = (r_rkind != KIND_RANGE);
                    n_oref = r_ref; n_osnd = r_snd;
                    n_i = '0;
                    waddr = r_sel; we = 1'b1;
                    if (r_ent.rcvd >= r_ent.total) begin
                        n_olast = (r_ent.total == '0);
                        n_rkind = KIND_COMPLETE;
                        wdata = '0;
                        n_state = (r_ent.total == '0) ? ST_IDLE : ST_READOUT;
                    end else begin
                        n_olast = 1'b1;
                        wdata = r_ent;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_READOUT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_okind = r_rkind; n_oslot = 3'(r_sel);
                    n_oidx = 4'(r_i); n_opres = r_ent.seen[r_i];
                    n_oref = r_ent.ref_num; n_osnd = r_ent.sender;
                    n_i = r_i + 1'b1;
                    n_olast = 1'b0;
                    if (PW'(r_i) + 1'b1 >= r_ent.total) begin
                        n_olast = (r_rkind == KIND_COMPLETE) || !r_free;
                        n_state = (r_rkind == KIND_COMPLETE) ? ST_IDLE : ST_WRCLR;
                    end
                end
            end
            ST_WRCLR: begin
                // timeout group already cleared; move to next slot
                n_g = r_g + 1'b1;
                raddr = r_g + 1'b1;
                n_state = last_g ? ST_IDLE : ST_TICK_RD;
            end
            ST_MARK_RD: begin
                n_state = ST_MARK_CHK;
            end
            ST_MARK_CHK: begin
                // flag every aged group first so the final flushed beat can carry last
                n_mask[r_g] = rdata.used && ((r_now - rdata.start) >= r_timeout);
                n_g = r_g + 1'b1;
                raddr = r_g + 1'b1;
                n_state = ST_MARK_RD;
                if (last_g) begin
                    n_g = '0;
                    raddr = '0;
                    n_state = ST_TICK_RD;
                end
            end
            ST_TICK_RD: begin
                n_state = ST_TICK_CHK;
            end
            ST_TICK_CHK: begin
                // r_free marks: a later slot is flagged too, so hold off last
                if (r_mask[r_g]) begin
                    we = 1'b1; wdata = '0; waddr = r_g;
                    n_ent = rdata; n_sel = r_g; n_i = '0; n_rkind = KIND_TIMEOUT;
                    n_free = later_flush;
                    n_state = (rdata.total == '0) ? ST_WRCLR : ST_READOUT;
                end else begin
                    n_g = r_g + 1'b1;
                    raddr = r_g + 1'b1;
                    n_state = last_g ? ST_IDLE : ST_TICK_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_timeout <= TIMEOUT_RESET; r_now <= '0;
            r_g <= '0; r_ov <= 1'b0; r_found <= 1'b0; r_free <= 1'b0;
        end else begin
            r_state <= n_state; r_now <= n_now; r_g <= n_g;
            r_ov <= n_ov; r_found <= n_found; r_free <= n_free;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel; r_best <= n_best; r_best_t <= n_best_t; r_i <= n_i;
        r_rkind <= n_rkind; r_ent <= n_ent; r_mask <= n_mask;
        r_okind <= n_okind; r_oslot <= n_oslot; r_oidx <= n_oidx; r_opres <= n_opres;
        r_olast <= n_olast; r_oref <= n_oref; r_osnd <= n_osnd;
        if (n_cmd_ld) begin
            r_ref <= s_axis_tdata[15:0];
            r_snd <= s_axis_tdata[79:16]; r_part <= s_axis_tdata[87:80];
            r_total <= s_axis_tdata[95:88];
        end
    end
endmodule
